### src/slpr_pkg.sv
// Package for the solar power limit regulator.
// Holds field widths, item types, register indexes and reset values.
// No dependencies.
package slpr_pkg;

    localparam int unsigned PowerW   = 16;
    localparam int unsigned CurrentW = 11;
    localparam int unsigned BusW     = 10;
    localparam int unsigned PvW      = 13;
    localparam int unsigned SocW     = 10;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned CfgIdxW  = 3;

    localparam int unsigned DefInitialPower  = 1000;
    localparam int unsigned DefRetryTimeS    = 300;
    localparam int unsigned DefRetryMinSocPc = 50;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PV_OUT_TOL   = 3'd0,
        REG_MAX_DIS_CUR  = 3'd1,
        REG_MIN_BUS_V    = 3'd2,
        REG_MIN_PV_V     = 3'd3,
        REG_MAX_PV_V     = 3'd4,
        REG_POWER_STEP   = 3'd5,
        REG_MIN_SOLAR_P  = 3'd6,
        REG_MAX_SOLAR_CAP = 3'd7
    } t_reg_idx;

    localparam logic [PowerW-1:0]          RstPvOutTol  = 16'd100;
    localparam logic signed [CurrentW-1:0] RstMaxDisCur = -11'sd20;
    localparam logic [BusW-1:0]            RstMinBusV   = 10'd350;
    localparam logic [PvW-1:0]             RstMinPvV    = 13'd1000;
    localparam logic [PvW-1:0]             RstMaxPvV    = 13'd1300;
    localparam logic [PowerW-1:0]          RstPowerStep = 16'd50;
    localparam logic [PowerW-1:0]          RstMinSolarP = 16'd0;
    localparam logic [PowerW-1:0]          RstSolarCap  = 16'd3000;

    typedef struct packed {
        logic [PowerW-1:0]          out_power_active;
        logic [PowerW-1:0]          pv_charging_power;
        logic signed [CurrentW-1:0] battery_current;
        logic [BusW-1:0]            bus_voltage;
        logic [PvW-1:0]             pv_voltage_dv;
        logic [SocW-1:0]            battery_soc_permille;
        logic [TimeW-1:0]           now_ms;
    } t_in_item;

endpackage

### src/slpr_ifs.sv
// Channel interfaces of the solar power limit regulator: report input,
// result output and configuration write. Depends on slpr_pkg.
interface slpr_in_if import slpr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [PowerW-1:0]          out_power_active;
    logic [PowerW-1:0]          pv_charging_power;
    logic signed [CurrentW-1:0] battery_current;
    logic [BusW-1:0]            bus_voltage;
    logic [PvW-1:0]             pv_voltage_dv;
    logic [SocW-1:0]            battery_soc_permille;
    logic [TimeW-1:0]           now_ms;

    modport source (
        output valid, out_power_active, pv_charging_power, battery_current,
               bus_voltage, pv_voltage_dv, battery_soc_permille, now_ms,
        input  ready
    );
    modport sink (
        input  valid, out_power_active, pv_charging_power, battery_current,
               bus_voltage, pv_voltage_dv, battery_soc_permille, now_ms,
        output ready
    );
endinterface

interface slpr_res_if import slpr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PowerW-1:0] max_solar_power;
    logic              is_cut_off;

    modport source (output valid, max_solar_power, is_cut_off, input ready);
    modport sink (input valid, max_solar_power, is_cut_off, output ready);
endinterface

interface slpr_cfg_if import slpr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/solar_power_limit_regulator.sv
// Solar power limit regulator: one result item per measurement report.
// Depends on slpr_pkg and the channel interfaces in slpr_ifs.sv.
//
// Usage:
//   i_in  : measurement reports (valid/ready). One item per report.
//   o_res : updated power limit and cut-off flag, one item per report,
//           in report order.
//   i_cfg : register writes (index, data); always ready. Write only while
//           no report is in flight.
// Path: an accepted report passes the input register, then the result
//   register, before its result is valid. Throughput: one report per
//   cycle while o_res takes results; limit state updates in the same
//   cycle the result register loads, so the next report sees it right away.
// Reset: synchronous, active low. Limit returns to INITIAL_POWER, cut-off
//   flag and time stamp clear, registers take their default values.
// Stall: when o_res is not taken, the result register holds, the input
//   register fills, and i_in.ready drops until the result moves on.
module solar_power_limit_regulator
    import slpr_pkg::*;
#(
    parameter int unsigned INITIAL_POWER     = DefInitialPower,
    parameter int unsigned RETRY_TIME_S      = DefRetryTimeS,
    parameter int unsigned RETRY_MIN_SOC_PCT = DefRetryMinSocPc
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slpr_in_if.sink    i_in,
    slpr_res_if.source o_res,
    slpr_cfg_if.sink   i_cfg
);

    localparam logic [PowerW-1:0] InitLimit   = PowerW'(INITIAL_POWER);
    localparam logic [TimeW-1:0]  RetryWaitMs = TimeW'(RETRY_TIME_S * 1000);
    localparam logic [SocW:0]     RetrySocPm  = (SocW + 1)'(RETRY_MIN_SOC_PCT * 10);

    // configuration registers
    logic [PowerW-1:0]          r_tol;
    logic signed [CurrentW-1:0] r_max_dis;
    logic [BusW-1:0]            r_min_bus;
    logic [PvW-1:0]             r_min_pv;
    logic [PvW-1:0]             r_max_pv;
    logic [PowerW-1:0]          r_step;
    logic [PowerW-1:0]          r_min_pwr;
    logic [PowerW-1:0]          r_cap;

    // limit state
    logic [PowerW-1:0] r_limit, n_limit;
    logic [TimeW-1:0]  r_stamp, n_stamp;
    logic              r_cut_flag, n_cut_flag;

    // input and result stages
    t_in_item          r_s1;
    logic              r_s1_vld;
    logic              r_out_vld;
    logic [PowerW-1:0] r_res_pwr;
    logic              r_res_cut;

    logic w_adv;
    logic w_calc;
    logic w_go_down;
    logic [TimeW-1:0] w_elapsed;
    logic signed [PowerW+1:0] w_headroom;

    assign w_adv  = !r_out_vld || o_res.ready;
    assign w_calc = r_s1_vld && w_adv;

    assign i_in.ready  = !r_s1_vld || w_adv;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid           = r_out_vld;
    assign o_res.max_solar_power = r_res_pwr;
    assign o_res.is_cut_off      = r_res_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= RstPvOutTol;
            r_max_dis <= RstMaxDisCur;
            r_min_bus <= RstMinBusV;
            r_min_pv  <= RstMinPvV;
            r_max_pv  <= RstMaxPvV;
            r_step    <= RstPowerStep;
            r_min_pwr <= RstMinSolarP;
            r_cap     <= RstSolarCap;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_PV_OUT_TOL:    r_tol     <= i_cfg.data;
                REG_MAX_DIS_CUR:   r_max_dis <= i_cfg.data[CurrentW-1:0];
                REG_MIN_BUS_V:     r_min_bus <= i_cfg.data[BusW-1:0];
                REG_MIN_PV_V:      r_min_pv  <= i_cfg.data[PvW-1:0];
                REG_MAX_PV_V:      r_max_pv  <= i_cfg.data[PvW-1:0];
                REG_POWER_STEP:    r_step    <= i_cfg.data;
                REG_MIN_SOLAR_P:   r_min_pwr <= i_cfg.data;
                REG_MAX_SOLAR_CAP: r_cap     <= i_cfg.data;
                default:           r_tol     <= r_tol;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.out_power_active     <= i_in.out_power_active;
            r_s1.pv_charging_power    <= i_in.pv_charging_power;
            r_s1.battery_current      <= i_in.battery_current;
            r_s1.bus_voltage          <= i_in.bus_voltage;
            r_s1.pv_voltage_dv        <= i_in.pv_voltage_dv;
            r_s1.battery_soc_permille <= i_in.battery_soc_permille;
            r_s1.now_ms               <= i_in.now_ms;
        end
    end

    assign w_go_down =
        ({1'b0, r_s1.out_power_active} > ({1'b0, r_s1.pv_charging_power} + {1'b0, r_tol}))
        || (r_s1.battery_current < r_max_dis)
        || (r_s1.bus_voltage < r_min_bus)
        || (r_s1.pv_voltage_dv < r_min_pv);

    // wraps modulo 2^32 so the retry check survives a counter rollover
    assign w_elapsed  = r_s1.now_ms - r_stamp;
    assign w_headroom = $signed({2'b00, r_cap}) - $signed({2'b00, r_step});

    always_comb begin
        n_limit    = r_limit;
        n_stamp    = r_stamp;
        n_cut_flag = r_cut_flag;
        if (w_calc) begin
            if (w_go_down) begin
                if (r_limit >= r_step && r_limit > r_min_pwr) begin
                    n_limit = r_limit - r_step;
                end else begin
                    // keep the first cut-off time on repeated cuts
                    if (!r_cut_flag) begin
                        n_stamp    = r_s1.now_ms;
                        n_cut_flag = 1'b1;
                    end
                    n_limit = '0;
                end
            end else if (r_limit == '0 && r_cut_flag) begin
                if (w_elapsed > RetryWaitMs && r_s1.bus_voltage > r_min_bus
                    && {1'b0, r_s1.battery_soc_permille} > RetrySocPm) begin
                    n_stamp    = '0;
                    n_cut_flag = 1'b0;
                    n_limit    = InitLimit;
                end
            end else if (r_s1.pv_voltage_dv > r_max_pv) begin
                if ($signed({2'b00, r_limit}) < w_headroom) begin
                    n_limit = r_limit + r_step;
                end else begin
                    n_limit = r_cap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= InitLimit;
            r_stamp    <= '0;
            r_cut_flag <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_limit    <= n_limit;
            r_stamp    <= n_stamp;
            r_cut_flag <= n_cut_flag;
            if (w_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_calc) begin
            r_res_pwr <= n_limit;
            r_res_cut <= n_cut_flag;
        end
    end

    // a cut-off always leaves the limit at zero until the retry
    a_cut_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cut_flag |-> (r_limit == '0))
        else $error("cut-off flag set with nonzero limit");

    a_stamp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cut_flag |-> (r_stamp == '0))
        else $error("cut-off stamp held without cut-off");

    a_stamp_on_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_cut_flag) |-> (r_stamp == $past(r_s1.now_ms)))
        else $error("cut-off stamp does not match report time");

    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_calc |=> (r_out_vld && r_res_pwr == r_limit && r_res_cut == r_cut_flag))
        else $error("result register disagrees with limit state");

endmodule

### dv/slpr_checker.sv
// Result checker for the solar power limit regulator testbench.
// Watches the report, result and register-write channels, keeps its own limit
// state, and compares each result item. Depends on slpr_pkg and slpr_ifs.sv.
module slpr_checker
    import slpr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    slpr_in_if   i_in,
    slpr_res_if  i_res,
    slpr_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RetryWaitMs      = DefRetryTimeS * 1000;
    localparam int unsigned RetrySocPermille = DefRetryMinSocPc * 10;

    typedef struct packed {
        logic [PowerW-1:0] max_solar_power;
        logic              is_cut_off;
    } t_limit_res;

    // register copies
    logic [PowerW-1:0]          reg_tol;
    logic signed [CurrentW-1:0] reg_dis_cur;
    logic [BusW-1:0]            reg_min_bus;
    logic [PvW-1:0]             reg_min_pv;
    logic [PvW-1:0]             reg_max_pv;
    logic [PowerW-1:0]          reg_pwr_step;
    logic [PowerW-1:0]          reg_min_pwr;
    logic [PowerW-1:0]          reg_cap;

    // regulator state
    logic [PowerW-1:0] limit_q;
    logic [TimeW-1:0]  stamp_q;
    logic              cut_q;

    t_limit_res expected_limits[$];
    int         error_count = 0;

    function automatic t_limit_res step_limit(input t_in_item r);
        logic [PowerW:0]  pv_margin;
        logic             go_down;
        logic [TimeW-1:0] elapsed;
        t_limit_res       res;
        pv_margin = {1'b0, r.pv_charging_power} + {1'b0, reg_tol};
        go_down = ({1'b0, r.out_power_active} > pv_margin) ||
                  ($signed(r.battery_current) < reg_dis_cur) ||
                  (r.bus_voltage < reg_min_bus) ||
                  (r.pv_voltage_dv < reg_min_pv);
        elapsed = r.now_ms - stamp_q;
        if (go_down) begin
            if (limit_q >= reg_pwr_step && limit_q > reg_min_pwr) begin
                limit_q = limit_q - reg_pwr_step;
            end else begin
                // keep the first cut-off time
                if (!cut_q) begin
                    stamp_q = r.now_ms;
                    cut_q   = 1'b1;
                end
                limit_q = '0;
            end
        end else if (limit_q == '0 && cut_q) begin
            if (elapsed > RetryWaitMs && r.bus_voltage > reg_min_bus &&
                r.battery_soc_permille > RetrySocPermille) begin
                stamp_q = '0;
                cut_q   = 1'b0;
                limit_q = PowerW'(DefInitialPower);
            end
        end else if (r.pv_voltage_dv > reg_max_pv) begin
            if (int'(limit_q) < int'(reg_cap) - int'(reg_pwr_step)) begin
                limit_q = limit_q + reg_pwr_step;
            end else begin
                limit_q = reg_cap;
            end
        end
        res.max_solar_power = limit_q;
        res.is_cut_off      = cut_q;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_limit_res want;
        if (!i_rst_n) begin
            reg_tol      = RstPvOutTol;
            reg_dis_cur  = RstMaxDisCur;
            reg_min_bus  = RstMinBusV;
            reg_min_pv   = RstMinPvV;
            reg_max_pv   = RstMaxPvV;
            reg_pwr_step = RstPowerStep;
            reg_min_pwr  = RstMinSolarP;
            reg_cap      = RstSolarCap;
            limit_q      = PowerW'(DefInitialPower);
            stamp_q      = '0;
            cut_q        = 1'b0;
            expected_limits.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_PV_OUT_TOL:    reg_tol      = i_cfg.data;
                    REG_MAX_DIS_CUR:   reg_dis_cur  = i_cfg.data[CurrentW-1:0];
                    REG_MIN_BUS_V:     reg_min_bus  = i_cfg.data[BusW-1:0];
                    REG_MIN_PV_V:      reg_min_pv   = i_cfg.data[PvW-1:0];
                    REG_MAX_PV_V:      reg_max_pv   = i_cfg.data[PvW-1:0];
                    REG_POWER_STEP:    reg_pwr_step = i_cfg.data;
                    REG_MIN_SOLAR_P:   reg_min_pwr  = i_cfg.data;
                    REG_MAX_SOLAR_CAP: reg_cap      = i_cfg.data;
                    default: ;
                endcase
            end
            // pop before push so an early result cannot match its own report
            if (i_res.valid && i_res.ready) begin
                if (expected_limits.size() == 0) begin
                    $error("unexpected result item: max_solar_power %0d, is_cut_off %0d",
                           i_res.max_solar_power, i_res.is_cut_off);
                    error_count++;
                end else begin
                    want = expected_limits.pop_front();
                    if (i_res.max_solar_power !== want.max_solar_power) begin
                        $error("max_solar_power mismatch: expected %0d, actual %0d",
                               want.max_solar_power, i_res.max_solar_power);
                        error_count++;
                    end
                    if (i_res.is_cut_off !== want.is_cut_off) begin
                        $error("is_cut_off mismatch: expected %0d, actual %0d",
                               want.is_cut_off, i_res.is_cut_off);
                        error_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_limits.push_back(step_limit('{
                    out_power_active:     i_in.out_power_active,
                    pv_charging_power:    i_in.pv_charging_power,
                    battery_current:      i_in.battery_current,
                    bus_voltage:          i_in.bus_voltage,
                    pv_voltage_dv:        i_in.pv_voltage_dv,
                    battery_soc_permille: i_in.battery_soc_permille,
                    now_ms:               i_in.now_ms}));
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_limits.size();
    end

endmodule

### dv/tb_solar_power_limit_regulator.sv
// Testbench top for the solar power limit regulator: clock, reset, report and
// register stimulus, result back-pressure and verdict. Checking lives in
// slpr_checker. Depends on slpr_pkg, slpr_ifs.sv and slpr_checker.sv.
module tb_solar_power_limit_regulator;
    timeunit 1ns;
    timeprecision 1ps;

    import slpr_pkg::*;

    localparam int QuietLimit   = 3000;
    localparam int HoldCycles   = 300;
    localparam int HoldAfter    = 150;
    localparam int RandPhases   = 8;
    localparam int PhaseReports = 60;

    typedef struct {
        logic [PowerW-1:0]          tol;
        logic signed [CurrentW-1:0] dis_cur;
        logic [BusW-1:0]            min_bus;
        logic [PvW-1:0]             min_pv;
        logic [PvW-1:0]             max_pv;
        logic [PowerW-1:0]          pwr_step;
        logic [PowerW-1:0]          min_pwr;
        logic [PowerW-1:0]          cap;
    } t_reg_set;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    // sender pacing and register mirror for report shaping
    int         burst_left = 0;
    bit         gaps_on = 1'b0;
    t_reg_set   regs_now;
    logic [31:0] clock_ms = '0;

    slpr_in_if  in_ch ();
    slpr_res_if res_ch ();
    slpr_cfg_if cfg_ch ();

    solar_power_limit_regulator uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    slpr_checker checker_i (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (fail_count),
        .o_pending (pending)
    );

    always #5 clk = ~clk;

    // abort when no channel moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: stall patterns, plus one long hold-off while reports keep coming
    initial begin
        int  mode = 0;
        int  mode_left = 0;
        int  taken = 0;
        bit  held = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready) taken++;
            if (!held && taken >= HoldAfter && in_ch.valid) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= 1'($urandom_range(0, 1));
                2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: res_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic t_in_item report_of(input int out_w, input int pv_w, input int cur_a,
                                           input int bus_v, input int pv_dv, input int soc,
                                           input logic [31:0] now);
        t_in_item r;
        r.out_power_active     = PowerW'(out_w);
        r.pv_charging_power    = PowerW'(pv_w);
        r.battery_current      = CurrentW'(cur_a);
        r.bus_voltage          = BusW'(bus_v);
        r.pv_voltage_dv        = PvW'(pv_dv);
        r.battery_soc_permille = SocW'(soc);
        r.now_ms               = now;
        return r;
    endfunction

    function automatic t_reg_set reset_regs();
        t_reg_set s;
        s.tol      = RstPvOutTol;
        s.dis_cur  = RstMaxDisCur;
        s.min_bus  = RstMinBusV;
        s.min_pv   = RstMinPvV;
        s.max_pv   = RstMaxPvV;
        s.pwr_step = RstPowerStep;
        s.min_pwr  = RstMinSolarP;
        s.cap      = RstSolarCap;
        return s;
    endfunction

    function automatic t_reg_set regulator_settings(input int phase);
        t_reg_set s;
        int       d;
        case (phase)
            1: begin
                s.tol = '0; s.dis_cur = CurrentW'(-1000); s.min_bus = '0; s.min_pv = '0;
                s.max_pv = '0; s.pwr_step = '0; s.min_pwr = '0; s.cap = '0;
            end
            2: begin
                s.tol = 16'hFFFF; s.dis_cur = '0; s.min_bus = 10'd1023; s.min_pv = 13'd5000;
                s.max_pv = 13'd5000; s.pwr_step = 16'hFFFF; s.min_pwr = 16'hFFFF;
                s.cap = 16'hFFFF;
            end
            4: begin
                d = -int'($urandom_range(0, 1000));
                s.tol      = PowerW'($urandom_range(0, 65535));
                s.dis_cur  = CurrentW'(d);
                s.min_bus  = BusW'($urandom_range(0, 1023));
                s.min_pv   = PvW'($urandom_range(0, 5000));
                s.max_pv   = PvW'($urandom_range(0, 5000));
                s.pwr_step = PowerW'($urandom_range(0, 65535));
                s.min_pwr  = PowerW'($urandom_range(0, 65535));
                s.cap      = PowerW'($urandom_range(0, 65535));
            end
            default: begin
                d = -int'($urandom_range(0, 100));
                s.tol      = PowerW'($urandom_range(0, 500));
                s.dis_cur  = CurrentW'(d);
                s.min_bus  = BusW'($urandom_range(300, 400));
                s.min_pv   = PvW'($urandom_range(800, 1100));
                s.max_pv   = PvW'($urandom_range(1200, 1500));
                s.pwr_step = PowerW'($urandom_range(20, 300));
                s.min_pwr  = PowerW'($urandom_range(0, 500));
                // one phase keeps the cap small, at 200 or below
                s.cap      = (phase == 6) ? PowerW'($urandom_range(0, 200))
                                          : PowerW'($urandom_range(1500, 4000));
            end
        endcase
        return s;
    endfunction

    // mostly well-formed reports shaped against the live register set
    function automatic t_in_item next_report();
        int roll, margin, dis, lo;
        int out_w, pv_w, cur_a, bus_v, pv_dv, soc;
        if ($urandom_range(0, 7) == 0) clock_ms += $urandom_range(250000, 400000);
        else clock_ms += $urandom_range(0, 30000);
        dis    = int'(regs_now.dis_cur);
        pv_w   = $urandom_range(0, 65535);
        margin = pv_w + int'(regs_now.tol);
        out_w  = $urandom_range(0, (margin > 65535) ? 65535 : margin);
        cur_a  = dis + int'($urandom_range(0, 1000 - dis));
        bus_v  = $urandom_range(regs_now.min_bus, 1023);
        pv_dv  = $urandom_range(regs_now.min_pv, 5000);
        soc    = $urandom_range(0, 1000);
        roll   = $urandom_range(0, 99);
        if (roll < 40) begin
            case ($urandom_range(0, 3))
                0: if (margin < 65535) out_w = $urandom_range(margin + 1, 65535);
                1: if (dis > -1000) cur_a = -1000 + int'($urandom_range(0, dis + 999));
                2: if (regs_now.min_bus > 0) bus_v = $urandom_range(0, regs_now.min_bus - 1);
                default: if (regs_now.min_pv > 0) pv_dv = $urandom_range(0, regs_now.min_pv - 1);
            endcase
        end else if (roll < 65) begin
            lo = int'(regs_now.max_pv) + 1;
            if (lo < int'(regs_now.min_pv)) lo = int'(regs_now.min_pv);
            if (lo <= 5000) pv_dv = $urandom_range(lo, 5000);
        end else if (roll < 90) begin
            if (regs_now.min_bus < 1023) bus_v = $urandom_range(regs_now.min_bus + 1, 1023);
            soc = $urandom_range(501, 1000);
        end else begin
            return report_of($urandom_range(0, 65535), $urandom_range(0, 65535),
                             int'($urandom_range(0, 2000)) - 1000, $urandom_range(0, 1023),
                             $urandom_range(0, 5000), $urandom_range(0, 1000), $urandom);
        end
        return report_of(out_w, pv_w, cur_a, bus_v, pv_dv, soc, clock_ms);
    endfunction

    task automatic push_report(input t_in_item r);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 5);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0) burst_left--;
        in_ch.valid                <= 1'b1;
        in_ch.out_power_active     <= r.out_power_active;
        in_ch.pv_charging_power    <= r.pv_charging_power;
        in_ch.battery_current      <= r.battery_current;
        in_ch.bus_voltage          <= r.bus_voltage;
        in_ch.pv_voltage_dv        <= r.pv_voltage_dv;
        in_ch.battery_soc_permille <= r.battery_soc_permille;
        in_ch.now_ms               <= r.now_ms;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // leaves valid high so back-to-back writes need no toggle
    task automatic write_reg(input t_reg_idx idx, input logic [CfgDataW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input t_reg_set s);
        drain();
        write_reg(REG_PV_OUT_TOL, s.tol);
        write_reg(REG_MAX_DIS_CUR, CfgDataW'(s.dis_cur));
        write_reg(REG_MIN_BUS_V, CfgDataW'(s.min_bus));
        write_reg(REG_MIN_PV_V, CfgDataW'(s.min_pv));
        write_reg(REG_MAX_PV_V, CfgDataW'(s.max_pv));
        write_reg(REG_POWER_STEP, s.pwr_step);
        write_reg(REG_MIN_SOLAR_P, s.min_pwr);
        write_reg(REG_MAX_SOLAR_CAP, s.cap);
        cfg_ch.valid <= 1'b0;
        regs_now = s;
    endtask

    initial begin
        t_reg_set s;
        rst_n                      = 1'b0;
        in_ch.valid                = 1'b0;
        in_ch.out_power_active     = '0;
        in_ch.pv_charging_power    = '0;
        in_ch.battery_current      = '0;
        in_ch.bus_voltage          = '0;
        in_ch.pv_voltage_dv        = '0;
        in_ch.battery_soc_permille = '0;
        in_ch.now_ms               = '0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.index               = REG_PV_OUT_TOL;
        cfg_ch.data                = '0;
        regs_now                   = reset_regs();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: hold, step up, field extremes, each step-down cause
        push_report(report_of(1000, 1000, 0, 400, 1200, 600, 0));
        push_report(report_of(1000, 1000, 0, 400, 1400, 600, 10));
        push_report(report_of(65535, 65535, 1000, 1023, 5000, 1000, 32'hFFFF_FFFF));
        push_report(report_of(65535, 0, 0, 400, 1200, 600, 20));
        push_report(report_of(0, 0, -1000, 400, 1200, 600, 30));
        push_report(report_of(0, 0, -21, 400, 1200, 600, 40));
        push_report(report_of(0, 0, 0, 0, 1200, 600, 50));
        push_report(report_of(0, 0, 0, 400, 0, 0, 60));

        // cut-off, repeated cut-off, retry just short, bus and charge not recovered,
        // then a time earlier than the stamp
        s = reset_regs();
        s.pwr_step = 16'd400;
        apply_settings(s);
        push_report(report_of(0, 0, 0, 0, 1200, 600, 1000));
        push_report(report_of(0, 0, 0, 0, 1200, 600, 2000));
        push_report(report_of(0, 0, 0, 0, 1200, 600, 5000));
        push_report(report_of(0, 0, 0, 0, 1200, 600, 9000));
        push_report(report_of(0, 0, 0, 400, 1200, 900, 305000));
        push_report(report_of(0, 0, 0, 350, 1200, 900, 305001));
        push_report(report_of(0, 0, 0, 400, 1200, 500, 305001));
        push_report(report_of(0, 0, 0, 400, 1200, 501, 100));

        // retry across counter wrap
        s.min_pwr  = 16'd2000;
        s.pwr_step = 16'd500;
        apply_settings(s);
        push_report(report_of(0, 0, 0, 0, 1200, 600, 32'hFFFF_F000));
        push_report(report_of(0, 0, 0, 1023, 1200, 1000, 32'h0005_0000));

        // zero limit reached by stepping, no cut-off flag
        s.min_pwr = 16'd0;
        apply_settings(s);
        push_report(report_of(0, 0, 0, 0, 1200, 600, 100));
        push_report(report_of(0, 0, 0, 0, 1200, 600, 200));
        push_report(report_of(0, 0, 0, 400, 5000, 600, 300));
        push_report(report_of(0, 0, 0, 0, 1200, 600, 400));
        push_report(report_of(0, 0, 0, 400, 1200, 600, 500));

        // step up while under the cap, cap under the limit, cap under the step
        s.cap      = 16'd100;
        s.pwr_step = 16'd50;
        apply_settings(s);
        push_report(report_of(0, 0, 0, 400, 5000, 600, 600));
        s.cap      = 16'd20;
        s.pwr_step = 16'd10;
        apply_settings(s);
        push_report(report_of(0, 0, 0, 400, 5000, 600, 700));
        s.cap      = 16'd5;
        s.pwr_step = 16'd500;
        apply_settings(s);
        push_report(report_of(0, 0, 0, 400, 5000, 600, 800));

        for (int phase = 0; phase < RandPhases; phase++) begin
            apply_settings(regulator_settings(phase));
            gaps_on    = (phase % 3 != 1);
            burst_left = 0;
            if (phase == 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1000000);
            for (int n = 0; n < PhaseReports; n++) push_report(next_report());
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
